@@ sv/lasl_pkg.sv @@
package lasl_pkg;

    // APB address and data widths
    localparam int ADDR_W = 5;
    localparam int IDX_W  = ADDR_W - 2;
    localparam int DATA_W = 32;

    // Field widths
    localparam int LEVEL_W = 12;
    localparam int STEP_W  = 8;
    localparam int ACCEL_W = 13;
    localparam int SPEED_W = 13;
    localparam int CODE_W  = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TURN_ON     = 3'd0;
    localparam logic [IDX_W-1:0] REG_TURN_OFF    = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRAIGHT    = 3'd2;
    localparam logic [IDX_W-1:0] REG_CURVE       = 3'd3;
    localparam logic [IDX_W-1:0] REG_SPEED_FLOOR = 3'd4;
    localparam logic [IDX_W-1:0] REG_SPEED_CAP   = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP        = 3'd6;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_TURN_ON     = 12'd300;
    localparam logic [LEVEL_W-1:0] RST_TURN_OFF    = 12'd50;
    localparam logic [LEVEL_W-1:0] RST_STRAIGHT    = 12'd150;
    localparam logic [LEVEL_W-1:0] RST_CURVE       = 12'd250;
    localparam logic [LEVEL_W-1:0] RST_SPEED_FLOOR = 12'd3600;
    localparam logic [LEVEL_W-1:0] RST_SPEED_CAP   = 12'd3950;
    localparam logic [STEP_W-1:0]  RST_STEP        = 8'd4;

    // Turn signal codes
    localparam logic [CODE_W-1:0] TURN_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] TURN_LEFT  = 2'd1;
    localparam logic [CODE_W-1:0] TURN_RIGHT = 2'd2;

    // Speed change codes
    localparam logic [CODE_W-1:0] CHG_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] CHG_ACCEL = 2'd1;
    localparam logic [CODE_W-1:0] CHG_DECEL = 2'd2;

    typedef struct packed {
        logic [LEVEL_W-1:0] turn_on_level;
        logic [LEVEL_W-1:0] turn_off_level;
        logic [LEVEL_W-1:0] straight_limit;
        logic [LEVEL_W-1:0] curve_limit;
        logic [LEVEL_W-1:0] speed_floor;
        logic [LEVEL_W-1:0] speed_cap;
        logic [STEP_W-1:0]  speed_step;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] drive_speed;
        logic [CODE_W-1:0]  speed_change;
        logic [CODE_W-1:0]  turn_state;
        logic               lamp_front_left;
        logic               lamp_front_right;
        logic               lamp_rear_left;
        logic               lamp_rear_right;
    } result_t;

endpackage

@@ sv/lateral_accel_speed_and_lights.sv @@
// An accepted item is captured in the input register and moves into the result register,
// which drives the m_ ports, when that is empty or being emptied; it leaves with m_ready high.
// Throughput: one item per cycle while m_ready is high; the speed and turn state loop closes
// through compares and one add, and the output register lets a new item enter while a result waits.
// Reset (synchronous, active low) empties both stages, clears the turn state, loads the
// registers with their defaults and sets the speed to the default minimum speed.
module lateral_accel_speed_and_lights (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lasl_pkg::ACCEL_W-1:0] s_accel_y,
    input  logic                                s_blink_phase,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lasl_pkg::SPEED_W-1:0]        m_drive_speed,
    output logic [lasl_pkg::CODE_W-1:0]         m_speed_change,
    output logic [lasl_pkg::CODE_W-1:0]         m_turn_state,
    output logic                                m_lamp_front_left,
    output logic                                m_lamp_front_right,
    output logic                                m_lamp_rear_left,
    output logic                                m_lamp_rear_right,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lasl_pkg::ADDR_W-1:0]         paddr,
    input  logic [lasl_pkg::DATA_W-1:0]         pwdata,
    output logic [lasl_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import lasl_pkg::*;

    cfg_t                      cfg;
    result_t                   res_next;
    result_t                   res_reg;
    logic                      in_valid_reg;
    logic signed [ACCEL_W-1:0] accel_reg;
    logic                      blink_reg;
    logic                      out_valid_reg;
    logic [CODE_W-1:0]         turn_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic                      advance;
    logic                      take_in;

    assign pready = 1'b1;

    lasl_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lasl_step u_step (
        .accel_y     (accel_reg),
        .blink_phase (blink_reg),
        .turn_cur    (turn_reg),
        .speed_cur   (speed_reg),
        .cfg         (cfg),
        .res         (res_next)
    );

    // The held item moves on when the result register is empty or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            turn_reg      <= TURN_NONE;
            speed_reg     <= {1'b0, RST_SPEED_FLOOR};
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                turn_reg      <= res_next.turn_state;
                speed_reg     <= res_next.drive_speed;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            accel_reg <= s_accel_y;
            blink_reg <= s_blink_phase;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_drive_speed      = res_reg.drive_speed;
    assign m_speed_change     = res_reg.speed_change;
    assign m_turn_state       = res_reg.turn_state;
    assign m_lamp_front_left  = res_reg.lamp_front_left;
    assign m_lamp_front_right = res_reg.lamp_front_right;
    assign m_lamp_rear_left   = res_reg.lamp_rear_left;
    assign m_lamp_rear_right  = res_reg.lamp_rear_right;

endmodule

@@ sv/lasl_regs.sv @@
module lasl_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lasl_pkg::ADDR_W-1:0]   paddr,
    input  logic [lasl_pkg::DATA_W-1:0]   pwdata,
    output logic [lasl_pkg::DATA_W-1:0]   prdata,
    output lasl_pkg::cfg_t                cfg
);
    import lasl_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_TURN_ON:     cfg_next.turn_on_level  = pwdata[LEVEL_W-1:0];
                REG_TURN_OFF:    cfg_next.turn_off_level = pwdata[LEVEL_W-1:0];
                REG_STRAIGHT:    cfg_next.straight_limit = pwdata[LEVEL_W-1:0];
                REG_CURVE:       cfg_next.curve_limit    = pwdata[LEVEL_W-1:0];
                REG_SPEED_FLOOR: cfg_next.speed_floor    = pwdata[LEVEL_W-1:0];
                REG_SPEED_CAP:   cfg_next.speed_cap      = pwdata[LEVEL_W-1:0];
                REG_STEP:        cfg_next.speed_step     = pwdata[STEP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.turn_on_level  <= RST_TURN_ON;
            cfg_reg.turn_off_level <= RST_TURN_OFF;
            cfg_reg.straight_limit <= RST_STRAIGHT;
            cfg_reg.curve_limit    <= RST_CURVE;
            cfg_reg.speed_floor    <= RST_SPEED_FLOOR;
            cfg_reg.speed_cap      <= RST_SPEED_CAP;
            cfg_reg.speed_step     <= RST_STEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_TURN_ON:     prdata = DATA_W'(cfg_reg.turn_on_level);
            REG_TURN_OFF:    prdata = DATA_W'(cfg_reg.turn_off_level);
            REG_STRAIGHT:    prdata = DATA_W'(cfg_reg.straight_limit);
            REG_CURVE:       prdata = DATA_W'(cfg_reg.curve_limit);
            REG_SPEED_FLOOR: prdata = DATA_W'(cfg_reg.speed_floor);
            REG_SPEED_CAP:   prdata = DATA_W'(cfg_reg.speed_cap);
            REG_STEP:        prdata = DATA_W'(cfg_reg.speed_step);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/lasl_step.sv @@
module lasl_step (
    input  logic signed [lasl_pkg::ACCEL_W-1:0] accel_y,
    input  logic                                blink_phase,
    input  logic [lasl_pkg::CODE_W-1:0]         turn_cur,
    input  logic [lasl_pkg::SPEED_W-1:0]        speed_cur,
    input  lasl_pkg::cfg_t                      cfg,
    output lasl_pkg::result_t                   res
);
    import lasl_pkg::*;

    localparam int CMP_W = ACCEL_W + 1;

    logic signed [CMP_W-1:0] y_ext;
    logic signed [CMP_W-1:0] on_pos;
    logic signed [CMP_W-1:0] on_neg;
    logic signed [CMP_W-1:0] off_pos;
    logic signed [CMP_W-1:0] off_neg;
    logic signed [CMP_W-1:0] mag_full;
    logic [ACCEL_W-1:0]      mag;
    logic [CODE_W-1:0]       turn_mid;
    logic [CODE_W-1:0]       turn_new;
    logic [SPEED_W-1:0]      speed_new;
    logic [CODE_W-1:0]       chg;
    logic                    accel_on;
    logic                    decel_on;

    assign y_ext    = CMP_W'(accel_y);
    assign on_pos   = $signed({2'b00, cfg.turn_on_level});
    assign on_neg   = -on_pos;
    assign off_pos  = $signed({2'b00, cfg.turn_off_level});
    assign off_neg  = -off_pos;
    // The most negative sample has magnitude 4096, which still fits the field width.
    assign mag_full = y_ext[CMP_W-1] ? -y_ext : y_ext;
    assign mag      = mag_full[ACCEL_W-1:0];

    always_comb begin
        case (turn_cur) inside
            TURN_LEFT, TURN_RIGHT: turn_mid = turn_cur;
            default:               turn_mid = TURN_NONE;
        endcase
        if (y_ext < on_neg) begin
            turn_mid = TURN_LEFT;
        end else if (y_ext > on_pos) begin
            turn_mid = TURN_RIGHT;
        end
        // A start and a clear can land in the same item when the off level is the larger.
        if ((y_ext > off_neg && turn_mid == TURN_LEFT) ||
            (y_ext < off_pos && turn_mid == TURN_RIGHT)) begin
            turn_new = TURN_NONE;
        end else begin
            turn_new = turn_mid;
        end
    end

    always_comb begin
        speed_new = speed_cur;
        chg       = CHG_NONE;
        if (mag < {1'b0, cfg.straight_limit}) begin
            if (speed_cur < {1'b0, cfg.speed_cap}) begin
                speed_new = speed_cur + {{(SPEED_W-STEP_W){1'b0}}, cfg.speed_step};
                chg       = CHG_ACCEL;
            end
        end else if (mag >= {1'b0, cfg.curve_limit}) begin
            if (speed_cur > {1'b0, cfg.speed_floor}) begin
                speed_new = {1'b0, cfg.speed_floor};
                chg       = CHG_DECEL;
            end
        end
    end

    assign accel_on = (chg == CHG_ACCEL);
    assign decel_on = (chg == CHG_DECEL);

    always_comb begin
        res.drive_speed  = speed_new;
        res.speed_change = chg;
        res.turn_state   = turn_new;
        case (turn_new)
            TURN_LEFT: begin
                res.lamp_front_left  = blink_phase;
                res.lamp_front_right = accel_on;
                res.lamp_rear_left   = 1'b0;
                res.lamp_rear_right  = decel_on;
            end
            TURN_RIGHT: begin
                res.lamp_front_left  = accel_on;
                res.lamp_front_right = blink_phase;
                res.lamp_rear_left   = decel_on;
                res.lamp_rear_right  = 1'b0;
            end
            default: begin
                res.lamp_front_left  = accel_on;
                res.lamp_front_right = accel_on;
                res.lamp_rear_left   = decel_on;
                res.lamp_rear_right  = decel_on;
            end
        endcase
    end

endmodule

@@ sv/lasl_checker.sv @@
module lasl_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [lasl_pkg::SPEED_W-1:0] m_drive_speed,
    input logic [lasl_pkg::CODE_W-1:0]  m_speed_change,
    input logic [lasl_pkg::CODE_W-1:0]  m_turn_state,
    input logic                         m_lamp_front_left,
    input logic                         m_lamp_front_right,
    input logic                         m_lamp_rear_left,
    input logic                         m_lamp_rear_right
);
    import lasl_pkg::*;

    // A stalled result keeps its speed and turn state.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_speed) && $stable(m_turn_state))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_turn_state == TURN_NONE || m_turn_state == TURN_LEFT ||
                     m_turn_state == TURN_RIGHT) &&
                    (m_speed_change == CHG_NONE || m_speed_change == CHG_ACCEL ||
                     m_speed_change == CHG_DECEL))
        else $error("unknown turn or speed change code");

    // Without a turn signal the lamps are symmetric and front and rear never light together.
    a_lamps_straight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_turn_state == TURN_NONE |->
            m_lamp_front_left == m_lamp_front_right &&
            m_lamp_rear_left == m_lamp_rear_right &&
            !(m_lamp_front_left && m_lamp_rear_left))
        else $error("lamp pattern wrong without turn signal");

endmodule

bind lateral_accel_speed_and_lights lasl_checker u_lasl_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_drive_speed      (m_drive_speed),
    .m_speed_change     (m_speed_change),
    .m_turn_state       (m_turn_state),
    .m_lamp_front_left  (m_lamp_front_left),
    .m_lamp_front_right (m_lamp_front_right),
    .m_lamp_rear_left   (m_lamp_rear_left),
    .m_lamp_rear_right  (m_lamp_rear_right)
);
